>>> rtl/fxa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fxa_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int WORD_WIDTH_DEF = 32;

   localparam int FIELD_WIDTH    = 32;
   localparam int OPCODE_WIDTH   = 4;
   localparam int REQ_DATA_WIDTH = 72;
   localparam int RSP_DATA_WIDTH = 40;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ADD          = 4'd0,
      OP_SUB          = 4'd1,
      OP_MUL          = 4'd2,
      OP_DIV          = 4'd3,
      OP_MIN          = 4'd4,
      OP_MAX          = 4'd5,
      OP_INC          = 4'd6,
      OP_DEC          = 4'd7,
      OP_INT_TO_FIXED = 4'd8,
      OP_FIXED_TO_INT = 4'd9
   } opcode_type;

endpackage

`default_nettype wire

>>> rtl/fxa_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring-division step: shift in the next dividend bit, trial subtract,
// shift the quotient bit into the freed low end.
module fxa_div_step #(
   parameter int WORD_WIDTH = fxa_pkg::WORD_WIDTH_DEF,
   parameter int DQ_WIDTH   = fxa_pkg::WORD_WIDTH_DEF + fxa_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [WORD_WIDTH-1:0] rem_i,
   input  wire logic [DQ_WIDTH-1:0]   dq_i,
   input  wire logic [WORD_WIDTH-1:0] dvs_i,
   output logic      [WORD_WIDTH-1:0] rem_o,
   output logic      [DQ_WIDTH-1:0]   dq_o,
   output logic      [WORD_WIDTH-1:0] dvs_o
);

   logic [WORD_WIDTH:0]   trial;
   logic [WORD_WIDTH:0]   diff;
   logic                  ge;
   logic [WORD_WIDTH-1:0] rem_ff, rem_in;
   logic [DQ_WIDTH-1:0]   dq_ff, dq_in;
   logic [WORD_WIDTH-1:0] dvs_ff;

   always_comb begin
      trial  = {rem_i, dq_i[DQ_WIDTH-1]};
      diff   = trial - {1'b0, dvs_i};
      ge     = ~diff[WORD_WIDTH];
      rem_in = ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
      dq_in  = {dq_i[DQ_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
         dvs_ff <= dvs_i;
      end
   end

   assign rem_o = rem_ff;
   assign dq_o  = dq_ff;
   assign dvs_o = dvs_ff;

endmodule

`default_nettype wire

>>> rtl/q24_8_fixed_point_alu_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed fixed-point arithmetic unit (Q24.8 by default). Each request carries an
// opcode and two raw operands; each response carries one raw result and the
// less/equal/greater flags comparing operand_a with operand_b (signed). All
// operations wrap to WORD_WIDTH bits; a zero divisor gives 0, unused opcodes give
// 0. The unit is fully pipelined: one transaction is accepted every cycle. The
// divider sets the pipeline depth, as it resolves one quotient bit per stage;
// every other operation rides along beside it so results stay in order.
// Backpressure on the response side freezes the whole pipeline.
module q24_8_fixed_point_alu_top #(
   parameter int FRAC_BITS  = fxa_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = fxa_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [3:0] opcode, [35:4] operand_a, [67:36] operand_b, [71:68] zero
   input  wire logic [fxa_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [31:0] result, [32] less, [33] equal, [34] greater, [39:35] zero
   output logic      [fxa_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   localparam int W  = WORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int N  = W + F;
   localparam int FW = fxa_pkg::FIELD_WIDTH;
   localparam int OW = fxa_pkg::OPCODE_WIDTH;

   // Advance every stage together whenever the output slot is free or drained.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Input decode: take the operands as signed words, compare them and compute the simple results.
   fxa_pkg::opcode_type op;
   logic signed [W-1:0] sa, sb;
   logic        [W-1:0] abs_a, abs_b, simple;
   logic                lt, eq, gt;

   always_comb begin
      op    = fxa_pkg::opcode_type'(req_tdata[OW-1:0]);
      sa    = req_tdata[OW +: W];
      sb    = req_tdata[OW+FW +: W];
      lt    = sa < sb;
      eq    = sa == sb;
      gt    = sa > sb;
      abs_a = sa[W-1] ? W'(-sa) : W'(sa);
      abs_b = sb[W-1] ? W'(-sb) : W'(sb);
      unique case (op)
         fxa_pkg::OP_ADD:          simple = W'(sa + sb);
         fxa_pkg::OP_SUB:          simple = W'(sa - sb);
         fxa_pkg::OP_MIN:          simple = lt ? sa : sb;
         fxa_pkg::OP_MAX:          simple = gt ? sa : sb;
         fxa_pkg::OP_INC:          simple = W'(sa + 1'b1);
         fxa_pkg::OP_DEC:          simple = W'(sa - 1'b1);
         fxa_pkg::OP_INT_TO_FIXED: simple = W'(sa << F);
         fxa_pkg::OP_FIXED_TO_INT: simple = W'(sa >>> F);
         default:                  simple = '0;
      endcase
   end

   // Side pipeline: valid, opcode, partial result, flags, divide sign and zero-divisor info.
   logic [N:0]                 vld_ff;
   fxa_pkg::opcode_type        op_pipe_ff   [0:N];
   logic [W-1:0]               res_pipe_ff  [0:N];
   logic [2:0]                 flag_pipe_ff [0:N];
   logic                       neg_pipe_ff  [0:N];
   logic                       bz_pipe_ff   [0:N];
   logic signed [2*W-1:0]      prod_ff;
   logic [N-1:0]               dq0_ff;
   logic [W-1:0]               dvs0_ff;

   // Divider chain wires; entry 0 is the first stage's registers, with a zero remainder.
   logic [W-1:0] rem_w [0:N];
   logic [N-1:0] dq_w  [0:N];
   logic [W-1:0] dvs_w [0:N];

   assign rem_w[0] = '0;
   assign dq_w[0]  = dq0_ff;
   assign dvs_w[0] = dvs0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N-1:0], req_tvalid};
      end
   end

   // First stage: capture the opcode, simple result and flags, the full product and divide setup.
   always_ff @(posedge clock) begin
      if (en) begin
         op_pipe_ff[0]   <= op;
         res_pipe_ff[0]  <= simple;
         flag_pipe_ff[0] <= {gt, eq, lt};
         neg_pipe_ff[0]  <= sa[W-1] ^ sb[W-1];
         bz_pipe_ff[0]   <= (sb == '0);
         prod_ff         <= sa * sb;
         dq0_ff          <= {abs_a, {F{1'b0}}};
         dvs0_ff         <= abs_b;
      end
   end

   // Arithmetic shift of the product, widened so any shift count stays in range.
   logic signed [2*W+F-1:0] prod_ext;
   logic        [W-1:0]     mul_res;
   assign prod_ext = (2*W+F)'(prod_ff);
   assign mul_res  = prod_ext[F +: W];

   for (genvar k = 0; k < N; k++) begin : g_stage
      fxa_div_step #(
         .WORD_WIDTH (W),
         .DQ_WIDTH   (N)
      ) u_step (
         .clock (clock),
         .en    (en),
         .rem_i (rem_w[k]),
         .dq_i  (dq_w[k]),
         .dvs_i (dvs_w[k]),
         .rem_o (rem_w[k+1]),
         .dq_o  (dq_w[k+1]),
         .dvs_o (dvs_w[k+1])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            op_pipe_ff[k+1]   <= op_pipe_ff[k];
            flag_pipe_ff[k+1] <= flag_pipe_ff[k];
            neg_pipe_ff[k+1]  <= neg_pipe_ff[k];
            bz_pipe_ff[k+1]   <= bz_pipe_ff[k];
            // Fold the multiply result in right after the product register.
            if (k == 0 && op_pipe_ff[k] == fxa_pkg::OP_MUL) begin
               res_pipe_ff[k+1] <= mul_res;
            end else begin
               res_pipe_ff[k+1] <= res_pipe_ff[k];
            end
         end
      end
   end

   // Output stage: pick the quotient for divides (zero for a zero divisor), apply its sign, widen.
   logic [W-1:0]         q_low, final_res;
   logic signed [W-1:0]  final_s;
   logic [FW-1:0]        res32;
   logic                 rsp_valid_ff;
   logic [FW+2:0]        rsp_data_ff;

   always_comb begin
      q_low = dq_w[N][W-1:0];
      if (op_pipe_ff[N] == fxa_pkg::OP_DIV) begin
         if (bz_pipe_ff[N]) begin
            final_res = '0;
         end else if (neg_pipe_ff[N]) begin
            final_res = W'(-q_low);
         end else begin
            final_res = q_low;
         end
      end else begin
         final_res = res_pipe_ff[N];
      end
      final_s = final_res;
      res32   = FW'(final_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {flag_pipe_ff[N], res32};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(fxa_pkg::RSP_DATA_WIDTH-FW-3){1'b0}}, rsp_data_ff};

`ifndef NO_ASSERTIONS
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot(rsp_tdata[FW+2:FW]))
      else $error("compare flags not one-hot");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted transaction missing from first stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[N] |=> rsp_tvalid)
      else $error("last stage transaction lost");
`endif

endmodule

`default_nettype wire
